@@ design/assert_macros.svh @@
// Assertion macros used by the checker file hsv2rgb_checker.sv.
// Each macro takes a label, the clock, the reset, and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked after the delay dly from the antecedent.
`define ASSERT_AFTER(label, clk, rst, dly, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

@@ design/hsv2rgb_pkg.sv @@
//------------------------------------------------------------------------------
// hsv2rgb_pkg
// Widths, constants and the hue sector code for the HSV to RGB converter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

   // Pixel field widths
   localparam int PIX_W    = 8;
   localparam int PACKED_W = 16;

   // Hue scaling: hue * 6 spans 11 bits, top 3 bits are the sector
   localparam int HUE_SECTORS = 6;
   localparam int SCALED_W    = 11;
   localparam int CHROMA_W    = 2 * PIX_W;
   localparam int PROD_W      = CHROMA_W + PIX_W;

   localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

   // Pipeline depth from accepted transaction to result strobe
   localparam int LATENCY = 3;

   // Hue sectors around the color circle
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW     = 3'd0,
      SECTOR_YELLOW_GREEN   = 3'd1,
      SECTOR_GREEN_CYAN     = 3'd2,
      SECTOR_CYAN_BLUE      = 3'd3,
      SECTOR_BLUE_MAGENTA   = 3'd4,
      SECTOR_MAGENTA_RED    = 3'd5
   } sector_type;

endpackage

`default_nettype wire

@@ design/hsv_to_rgb_pixel_converter.sv @@
//------------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter
// Three-stage pipelined 8-bit HSV to RGB888 / RGB565 pixel converter.
//------------------------------------------------------------------------------
// Takes one pixel per clock. A transaction accepted on start appears on the
// rsp_ ports after the s1-s3 registers, with rsp_strobe for one cycle. busy is
// always low: the pipeline never stalls, so results must be taken as they come.
// The latency is set by the multiply chain: stage 1 forms hue*6 and the chroma
// (brightness*saturation), stage 2 multiplies the chroma by the sector fraction
// and its complement, stage 3 subtracts, routes by sector and packs RGB565.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_pixel_converter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [hsv2rgb_pkg::PIX_W-1:0]     req_hue,
   input  wire logic [hsv2rgb_pkg::PIX_W-1:0]     req_saturation,
   input  wire logic [hsv2rgb_pkg::PIX_W-1:0]     req_brightness,
   output logic                                   rsp_strobe,
   output logic [hsv2rgb_pkg::PIX_W-1:0]          rsp_red,
   output logic [hsv2rgb_pkg::PIX_W-1:0]          rsp_green,
   output logic [hsv2rgb_pkg::PIX_W-1:0]          rsp_blue,
   output logic [hsv2rgb_pkg::PACKED_W-1:0]       rsp_packed_565
);

   localparam int PW = hsv2rgb_pkg::PIX_W;

   // Stage 1 registers: scaled hue, chroma, brightness
   logic                                s1_valid_ff, s1_valid_in;
   logic [hsv2rgb_pkg::SCALED_W-1:0]    s1_scaled_ff, s1_scaled_in;
   logic [hsv2rgb_pkg::CHROMA_W-1:0]    s1_chroma_ff, s1_chroma_in;
   logic [PW-1:0]                       s1_val_ff, s1_val_in;

   // Stage 2 registers: products, minimum component, sector
   logic                                s2_valid_ff, s2_valid_in;
   logic [hsv2rgb_pkg::PROD_W-1:0]      s2_prod_down_ff, s2_prod_down_in;
   logic [hsv2rgb_pkg::PROD_W-1:0]      s2_prod_up_ff, s2_prod_up_in;
   logic [PW-1:0]                       s2_lo_ff, s2_lo_in;
   logic [PW-1:0]                       s2_val_ff, s2_val_in;
   hsv2rgb_pkg::sector_type             s2_sector_ff, s2_sector_in;

   // Stage 3 registers: result outputs
   logic                                s3_valid_ff, s3_valid_in;
   logic [PW-1:0]                       s3_red_ff, s3_red_in;
   logic [PW-1:0]                       s3_green_ff, s3_green_in;
   logic [PW-1:0]                       s3_blue_ff, s3_blue_in;

   logic [PW-1:0]                       s1_frac;
   logic [PW-1:0]                       s2_down;
   logic [PW-1:0]                       s2_up;

   // Stage 1: hue * 6 and brightness * saturation
   always_comb begin
      s1_valid_in  = start;
      s1_scaled_in = hsv2rgb_pkg::SCALED_W'(req_hue) *
                     hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::HUE_SECTORS);
      s1_chroma_in = hsv2rgb_pkg::CHROMA_W'(req_brightness) *
                     hsv2rgb_pkg::CHROMA_W'(req_saturation);
      s1_val_in    = req_brightness;
   end

   // Stage 2: chroma scaled by the fraction and its complement
   always_comb begin
      s1_frac         = s1_scaled_ff[PW-1:0];
      s2_valid_in     = s1_valid_ff;
      s2_prod_down_in = hsv2rgb_pkg::PROD_W'(s1_chroma_ff) *
                        hsv2rgb_pkg::PROD_W'(s1_frac);
      s2_prod_up_in   = hsv2rgb_pkg::PROD_W'(s1_chroma_ff) *
                        hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::FULL_SCALE - s1_frac);
      s2_lo_in        = s1_val_ff - s1_chroma_ff[hsv2rgb_pkg::CHROMA_W-1:PW];
      s2_val_in       = s1_val_ff;
      s2_sector_in    = hsv2rgb_pkg::sector_type'(
                           s1_scaled_ff[hsv2rgb_pkg::SCALED_W-1:PW]);
   end

   // Stage 3: descending/ascending components and sector routing
   always_comb begin
      s2_down     = s2_val_ff - s2_prod_down_ff[hsv2rgb_pkg::PROD_W-1:2*PW];
      s2_up       = s2_val_ff - s2_prod_up_ff[hsv2rgb_pkg::PROD_W-1:2*PW];
      s3_valid_in = s2_valid_ff;
      case (s2_sector_ff)
         hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
            s3_red_in = s2_val_ff; s3_green_in = s2_up;     s3_blue_in = s2_lo_ff;
         end
         hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
            s3_red_in = s2_down;   s3_green_in = s2_val_ff; s3_blue_in = s2_lo_ff;
         end
         hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
            s3_red_in = s2_lo_ff;  s3_green_in = s2_val_ff; s3_blue_in = s2_up;
         end
         hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
            s3_red_in = s2_lo_ff;  s3_green_in = s2_down;   s3_blue_in = s2_val_ff;
         end
         hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
            s3_red_in = s2_up;     s3_green_in = s2_lo_ff;  s3_blue_in = s2_val_ff;
         end
         default: begin
            s3_red_in = s2_val_ff; s3_green_in = s2_lo_ff;  s3_blue_in = s2_down;
         end
      endcase
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Data registers
   always_ff @(posedge clock) begin
      s1_scaled_ff    <= s1_scaled_in;
      s1_chroma_ff    <= s1_chroma_in;
      s1_val_ff       <= s1_val_in;
      s2_prod_down_ff <= s2_prod_down_in;
      s2_prod_up_ff   <= s2_prod_up_in;
      s2_lo_ff        <= s2_lo_in;
      s2_val_ff       <= s2_val_in;
      s2_sector_ff    <= s2_sector_in;
      s3_red_ff       <= s3_red_in;
      s3_green_ff     <= s3_green_in;
      s3_blue_ff      <= s3_blue_in;
   end

   // Outputs
   assign busy           = 1'b0;
   assign rsp_strobe     = s3_valid_ff;
   assign rsp_red        = s3_red_ff;
   assign rsp_green      = s3_green_ff;
   assign rsp_blue       = s3_blue_ff;
   assign rsp_packed_565 = {s3_red_ff[PW-1:3], s3_green_ff[PW-1:2], s3_blue_ff[PW-1:3]};

endmodule

`default_nettype wire

@@ design/hsv2rgb_checker.sv @@
//------------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hsv2rgb_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic [hsv2rgb_pkg::PIX_W-1:0]     req_hue,
   input wire logic [hsv2rgb_pkg::PIX_W-1:0]     req_saturation,
   input wire logic [hsv2rgb_pkg::PIX_W-1:0]     req_brightness,
   input wire logic                              rsp_strobe,
   input wire logic [hsv2rgb_pkg::PIX_W-1:0]     rsp_red,
   input wire logic [hsv2rgb_pkg::PIX_W-1:0]     rsp_green,
   input wire logic [hsv2rgb_pkg::PIX_W-1:0]     rsp_blue,
   input wire logic [hsv2rgb_pkg::PACKED_W-1:0]  rsp_packed_565
);

   // Every accepted transaction strobes a result after the pipeline latency
   `ASSERT_AFTER(a_result_follows, clock, reset, 3, start && !busy, rsp_strobe, "result missing")

   // No result unless start was high the pipeline latency earlier
   `ASSERT_AFTER(a_no_spurious, clock, reset, 3, !start, !rsp_strobe, "spurious result")

   // The packed word agrees with the 8-bit channels
   `ASSERT_IMPLIES(a_pack_match, clock, reset, rsp_strobe, rsp_packed_565 == {rsp_red[7:3], rsp_green[7:2], rsp_blue[7:3]}, "packed word mismatch")

   // Grey input gives all channels equal to the brightness
   `ASSERT_AFTER(a_grey, clock, reset, 3, start && req_saturation == 8'd0, rsp_red == $past(req_brightness, 3) && rsp_green == $past(req_brightness, 3) && rsp_blue == $past(req_brightness, 3), "grey mismatch")

   // One channel always carries the brightness
   `ASSERT_IMPLIES(a_peak_channel, clock, reset, rsp_strobe, rsp_red == $past(req_brightness, 3) || rsp_green == $past(req_brightness, 3) || rsp_blue == $past(req_brightness, 3), "no channel at brightness")

endmodule

bind hsv_to_rgb_pixel_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

`default_nettype wire

@@ tb/hsv_to_rgb_pixel_converter_checker.sv @@
//------------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter_checker
// Watches the request and response channels of the HSV to RGB converter,
// predicts every pixel from its own integer model and compares in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_converter_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic [hsv2rgb_pkg::PIX_W-1:0]       req_hue,
   input  wire logic [hsv2rgb_pkg::PIX_W-1:0]       req_saturation,
   input  wire logic [hsv2rgb_pkg::PIX_W-1:0]       req_brightness,
   input  wire logic                                rsp_strobe,
   input  wire logic [hsv2rgb_pkg::PIX_W-1:0]       rsp_red,
   input  wire logic [hsv2rgb_pkg::PIX_W-1:0]       rsp_green,
   input  wire logic [hsv2rgb_pkg::PIX_W-1:0]       rsp_blue,
   input  wire logic [hsv2rgb_pkg::PACKED_W-1:0]    rsp_packed_565,
   output int                                       fail_count,
   output int                                       pending_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [hsv2rgb_pkg::PIX_W-1:0]    red;
      logic [hsv2rgb_pkg::PIX_W-1:0]    green;
      logic [hsv2rgb_pkg::PIX_W-1:0]    blue;
      logic [hsv2rgb_pkg::PACKED_W-1:0] packed_565;
   } rgb_pixel_type;

   // Expected pixel together with the HSV input that produced it
   typedef struct packed {
      logic [hsv2rgb_pkg::PIX_W-1:0] hue;
      logic [hsv2rgb_pkg::PIX_W-1:0] saturation;
      logic [hsv2rgb_pkg::PIX_W-1:0] brightness;
      rgb_pixel_type                 rgb;
   } pixel_expectation_type;

   pixel_expectation_type expected_pixels[$];
   int                    mismatch_count = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Integer HSV to RGB conversion: six hue sectors, chroma = value * sat
   function automatic rgb_pixel_type hsv_to_rgb(input logic [hsv2rgb_pkg::PIX_W-1:0] hue,
                                                input logic [hsv2rgb_pkg::PIX_W-1:0] sat,
                                                input logic [hsv2rgb_pkg::PIX_W-1:0] bri);
      logic [hsv2rgb_pkg::SCALED_W-1:0] scaled;
      hsv2rgb_pkg::sector_type          sector;
      logic [hsv2rgb_pkg::PIX_W-1:0]    frac;
      logic [hsv2rgb_pkg::CHROMA_W-1:0] chroma;
      logic [hsv2rgb_pkg::PROD_W-1:0]   down_prod;
      logic [hsv2rgb_pkg::PROD_W-1:0]   up_prod;
      logic [hsv2rgb_pkg::PIX_W-1:0]    lo_level;
      logic [hsv2rgb_pkg::PIX_W-1:0]    down_level;
      logic [hsv2rgb_pkg::PIX_W-1:0]    up_level;
      logic [hsv2rgb_pkg::PIX_W-1:0]    r;
      logic [hsv2rgb_pkg::PIX_W-1:0]    g;
      logic [hsv2rgb_pkg::PIX_W-1:0]    b;
      rgb_pixel_type                    px;
      scaled     = hsv2rgb_pkg::SCALED_W'(hue) *
                   hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::HUE_SECTORS);
      sector     = hsv2rgb_pkg::sector_type'(
                      scaled[hsv2rgb_pkg::SCALED_W-1:hsv2rgb_pkg::PIX_W]);
      frac       = scaled[hsv2rgb_pkg::PIX_W-1:0];
      chroma     = hsv2rgb_pkg::CHROMA_W'(bri) * hsv2rgb_pkg::CHROMA_W'(sat);
      down_prod  = hsv2rgb_pkg::PROD_W'(chroma) * hsv2rgb_pkg::PROD_W'(frac);
      up_prod    = hsv2rgb_pkg::PROD_W'(chroma) *
                   hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::FULL_SCALE - frac);
      // subtracted terms never exceed the brightness, so no underflow
      lo_level   = bri - chroma[hsv2rgb_pkg::CHROMA_W-1:hsv2rgb_pkg::PIX_W];
      down_level = bri - down_prod[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::CHROMA_W];
      up_level   = bri - up_prod[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::CHROMA_W];
      case (sector)
         hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
            r = bri;        g = up_level;   b = lo_level;
         end
         hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
            r = down_level; g = bri;        b = lo_level;
         end
         hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
            r = lo_level;   g = bri;        b = up_level;
         end
         hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
            r = lo_level;   g = down_level; b = bri;
         end
         hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
            r = up_level;   g = lo_level;   b = bri;
         end
         default: begin
            r = bri;        g = lo_level;   b = down_level;
         end
      endcase
      px.red        = r;
      px.green      = g;
      px.blue       = b;
      // RGB565: top 5 bits of red, top 6 of green, top 5 of blue
      px.packed_565 = {r[7:3], g[7:2], b[7:3]};
      return px;
   endfunction

   // Compare responses against the oldest prediction, then log new requests
   always @(posedge clock) begin
      pixel_expectation_type exp_px;
      if (reset) begin
         expected_pixels.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("[%0t] unexpected pixel rgb=(%0d,%0d,%0d) 565=%h", $realtime,
                           rsp_red, rsp_green, rsp_blue, rsp_packed_565);
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_red !== exp_px.rgb.red || rsp_green !== exp_px.rgb.green ||
                   rsp_blue !== exp_px.rgb.blue ||
                   rsp_packed_565 !== exp_px.rgb.packed_565) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"[%0t] pixel mismatch hsv=(%0d,%0d,%0d)",
                               " exp rgb=(%0d,%0d,%0d) 565=%h",
                               " got rgb=(%0d,%0d,%0d) 565=%h"},
                              $realtime, exp_px.hue, exp_px.saturation, exp_px.brightness,
                              exp_px.rgb.red, exp_px.rgb.green, exp_px.rgb.blue,
                              exp_px.rgb.packed_565, rsp_red, rsp_green, rsp_blue,
                              rsp_packed_565);
               end
            end
         end
         if (start && !busy) begin
            exp_px.hue        = req_hue;
            exp_px.saturation = req_saturation;
            exp_px.brightness = req_brightness;
            exp_px.rgb        = hsv_to_rgb(req_hue, req_saturation, req_brightness);
            expected_pixels.push_back(exp_px);
         end
      end
      fail_count    <= mismatch_count;
      pending_count <= expected_pixels.size();
   end

endmodule

@@ tb/hsv_to_rgb_pixel_converter_tb.sv @@
//------------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter_tb
// Drives HSV pixels into the converter: sector boundaries, mid-sector, grey and
// extreme levels first, then random pixels under light, heavy and no sender idling.
// A side checker predicts every RGB888 / RGB565 result; this top gives the
// verdict.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_converter_tb;

   localparam int CYCLE_LIMIT   = 50000;
   localparam int PHASE_PIXELS  = 150;

   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                start          = 1'b0;
   logic                                busy;
   logic [hsv2rgb_pkg::PIX_W-1:0]       req_hue        = '0;
   logic [hsv2rgb_pkg::PIX_W-1:0]       req_saturation = '0;
   logic [hsv2rgb_pkg::PIX_W-1:0]       req_brightness = '0;
   logic                                rsp_strobe;
   logic [hsv2rgb_pkg::PIX_W-1:0]       rsp_red;
   logic [hsv2rgb_pkg::PIX_W-1:0]       rsp_green;
   logic [hsv2rgb_pkg::PIX_W-1:0]       rsp_blue;
   logic [hsv2rgb_pkg::PACKED_W-1:0]    rsp_packed_565;
   int                                  fail_count;
   int                                  pending_count;
   int                                  cycle_count    = 0;

   always #2 clock = ~clock;

   hsv_to_rgb_pixel_converter u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_strobe     (rsp_strobe),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_packed_565 (rsp_packed_565)
   );

   hsv_to_rgb_pixel_converter_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_strobe     (rsp_strobe),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_packed_565 (rsp_packed_565),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("hsv_to_rgb_pixel_converter test failed");
         $finish;
      end
   end

   // Present one pixel and hold it until the transaction is taken; start stays high
   task automatic send_pixel(input logic [hsv2rgb_pkg::PIX_W-1:0] hue,
                             input logic [hsv2rgb_pkg::PIX_W-1:0] sat,
                             input logic [hsv2rgb_pkg::PIX_W-1:0] bri);
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Idle the request side with the given per-cycle chance (percent)
   task automatic sender_gap(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         while ($urandom_range(99) < idle_pct) @(posedge clock);
         @(posedge clock);
      end
   endtask

   // Stop sending until every outstanding pixel has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Levels biased toward the extremes
   function automatic logic [hsv2rgb_pkg::PIX_W-1:0] random_level();
      case ($urandom_range(7))
         0:       return '0;
         1:       return hsv2rgb_pkg::FULL_SCALE;
         default: return hsv2rgb_pkg::PIX_W'($urandom_range(255));
      endcase
   endfunction

   task automatic random_phase(input int idle_pct);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
         sender_gap(idle_pct);
         send_pixel(random_level(), random_level(), random_level());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // extremes and grey pixels
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd128, 8'd0,   8'd77);
      send_pixel(8'd200, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      // both sides of every sector boundary, full saturation
      send_pixel(8'd42,  8'd255, 8'd255);
      send_pixel(8'd43,  8'd255, 8'd255);
      send_pixel(8'd85,  8'd255, 8'd200);
      send_pixel(8'd86,  8'd255, 8'd200);
      send_pixel(8'd127, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd255, 8'd255);
      send_pixel(8'd170, 8'd255, 8'd180);
      send_pixel(8'd171, 8'd255, 8'd180);
      send_pixel(8'd213, 8'd255, 8'd255);
      send_pixel(8'd214, 8'd255, 8'd255);
      // mid-sector pixels at partial saturation
      send_pixel(8'd21,  8'd128, 8'd170);
      send_pixel(8'd64,  8'd1,   8'd254);
      send_pixel(8'd107, 8'd170, 8'd85);
      send_pixel(8'd150, 8'd85,  8'd255);
      send_pixel(8'd192, 8'd254, 8'd1);
      send_pixel(8'd234, 8'd200, 8'd128);
      wait_drained();

      random_phase(11);
      wait_drained();
      random_phase(76);
      random_phase(0);

      wait_drained();
      repeat (hsv2rgb_pkg::LATENCY + 4) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("hsv_to_rgb_pixel_converter test passed");
      end else begin
         $display("hsv_to_rgb_pixel_converter test failed");
      end
      $finish;
   end

endmodule
